// ===== rtl/hge_pkg.sv =====
// Shared constants, codes and control structs for the histogram equalizer.
package hge_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int BINS            = 256;
    localparam int PIX_W           = 8;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int NUM_W           = CNT_W + PIX_W;
    localparam int QUO_W           = 8;
    localparam int STEP_W          = $clog2(QUO_W);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_COUNT = 2'd1;
    localparam logic [1:0] ACT_MAP   = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear;
        logic cnt_rd;
        logic cnt_wr;
        logic bld_init;
        logic bld_rd;
        logic bld_acc;
        logic div_load;
        logic div_step;
        logic map_write;
        logic set_ready;
        logic map_rd;
        logic out_load;
    } hge_cmd_t;

    typedef struct packed {
        logic last;
        logic idx_last;
        logic out_busy;
    } hge_status_t;

endpackage

// ===== rtl/gray_histogram_equalizer.sv =====
// Channel   Signals                               Direction
// input     in_valid, in_stall, action,           in (in_stall out)
//           pixel, last_count
// output    out_valid, out_stall, equalized,      out (out_stall in)
//           overflow
// A clear acts while idle; a count reads, then writes its bin; a map reads the
// table, then waits out any output stall. A count marked last adds a table build:
// per bin a histogram read, an add, a scale step, an 8-step restoring divider.
// Reset empties the histogram at once through per-bin valid flags.
// in_stall is high whenever the sequencer is busy with a word.
module gray_histogram_equalizer
    import hge_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [PIX_W-1:0] pixel,
    input  logic             last_count,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] equalized,
    output logic             overflow
);

    hge_cmd_t    cmd;
    hge_status_t status;
    logic        idle;

    hge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .idle     (idle),
        .cmd      (cmd)
    );

    hge_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pixel      (pixel),
        .last_count (last_count),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .equalized  (equalized),
        .overflow   (overflow)
    );

    assign in_stall = ~idle;

endmodule

// ===== rtl/hge_ram.sv =====
// Generic single write port, single registered read port RAM.
module hge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hge_ctrl.sv =====
// Sequencing state machine for count, map and table build.
module hge_ctrl
    import hge_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  action,
    input  hge_status_t status,
    output logic        idle,
    output hge_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_BLD_RD,
        S_BLD_ACC,
        S_BLD_MUL,
        S_BLD_DIV,
        S_BLD_WR,
        S_MAP_RD,
        S_MAP_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    // drop an unknown action word
                    unique case (action)
                        ACT_CLEAR: cmd.clear = 1'b1;
                        ACT_COUNT: state_next = S_CNT_RD;
                        ACT_MAP:   state_next = S_MAP_RD;
                        default:   ;
                    endcase
                end
            end
            S_CNT_RD:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.cnt_wr = 1'b1;
                if (status.last)
                begin
                    cmd.bld_init = 1'b1;
                    state_next   = S_BLD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BLD_RD:
            begin
                cmd.bld_rd = 1'b1;
                state_next = S_BLD_ACC;
            end
            S_BLD_ACC:
            begin
                cmd.bld_acc = 1'b1;
                state_next  = S_BLD_MUL;
            end
            S_BLD_MUL:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_BLD_DIV;
            end
            S_BLD_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = S_BLD_WR;
                end
            end
            S_BLD_WR:
            begin
                cmd.map_write = 1'b1;
                if (status.idx_last)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_BLD_RD;
                end
            end
            S_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_MAP_OUT;
            end
            S_MAP_OUT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// ===== rtl/hge_datapath.sv =====
// Histogram store, running sum, divider, mapping table and output register.
module hge_datapath
    import hge_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  hge_cmd_t         cmd,
    input  logic [PIX_W-1:0] pixel,
    input  logic             last_count,
    input  logic             out_stall,
    output hge_status_t      status,
    output logic             out_valid,
    output logic [PIX_W-1:0] equalized,
    output logic             overflow
);

    logic [PIX_W-1:0] pix_reg;
    logic             last_reg;
    logic [BINS-1:0]  vld_reg;
    logic             vld_q_reg;
    logic [CNT_W-1:0] total_reg;
    logic             ovf_reg;
    logic             ready_reg;
    logic [PIX_W-1:0] idx_reg;
    logic [CNT_W-1:0] run_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] equalized_reg;
    logic             overflow_reg;

    logic             bin_rd;
    logic [PIX_W-1:0] bin_addr;
    logic [CNT_W-1:0] bin_rdata;
    logic [CNT_W-1:0] bin_val;
    logic             full;
    logic [PIX_W-1:0] map_rdata;
    logic [PIX_W-1:0] map_wdata;
    logic [CNT_W:0]   two_rem;
    logic             round_up;
    logic             rem_ge;

    assign bin_rd   = cmd.cnt_rd | cmd.bld_rd;
    assign bin_addr = cmd.bld_rd ? idx_reg : pix_reg;
    assign bin_val  = vld_q_reg ? bin_rdata : '0;
    // total never exceeds capacity, so its top bit marks a full frame
    assign full     = total_reg[CNT_W-1];

    hge_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_bins (
        .clk     (clk),
        .wr_en   (cmd.cnt_wr & ~full),
        .wr_addr (pix_reg),
        .wr_data (bin_val + 1'b1),
        .rd_en   (bin_rd),
        .rd_addr (bin_addr),
        .rd_data (bin_rdata)
    );

    assign rem_ge   = (rem_reg >= den_reg);
    assign two_rem  = {rem_reg[CNT_W-1:0], 1'b0};
    assign round_up = (two_rem > {1'b0, total_reg})
                   || ((two_rem == {1'b0, total_reg}) && quo_reg[0]);

    always_comb
    begin
        if (total_reg == '0)
            map_wdata = '0;
        else if (round_up && (quo_reg != '1))
            map_wdata = quo_reg + 1'b1;
        else
            map_wdata = quo_reg;
    end

    hge_ram #(.WIDTH(PIX_W), .DEPTH(BINS)) u_map (
        .clk     (clk),
        .wr_en   (cmd.map_write),
        .wr_addr (idx_reg),
        .wr_data (map_wdata),
        .rd_en   (cmd.map_rd),
        .rd_addr (pix_reg),
        .rd_data (map_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg  <= pixel;
            last_reg <= last_count;
        end
        if (bin_rd)
        begin
            vld_q_reg <= vld_reg[bin_addr];
        end
        if (cmd.bld_acc)
        begin
            run_reg <= run_reg + bin_val;
        end
        else if (cmd.bld_init)
        begin
            run_reg <= '0;
        end
        if (cmd.div_load)
        begin
            // run * 255 without a multiplier
            rem_reg <= {run_reg, {PIX_W{1'b0}}} - NUM_W'(run_reg);
            den_reg <= NUM_W'(total_reg) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - den_reg;
            den_reg <= den_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            equalized_reg <= ready_reg ? map_rdata : '0;
            overflow_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            ready_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                vld_reg   <= '0;
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.cnt_wr)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    vld_reg[pix_reg] <= 1'b1;
                    total_reg        <= total_reg + 1'b1;
                end
            end
            if (cmd.bld_init)
                idx_reg <= '0;
            else if (cmd.map_write)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.set_ready)
                ready_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.idx_last = (idx_reg == '1);
    assign status.out_busy = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign equalized = equalized_reg;
    assign overflow  = overflow_reg;

endmodule
